// ===== sv/rclas_pkg.sv =====
// Package for the RC link and arm/mode supervisor.
// Holds the shared types, register codes, reset values, stream packing and
// threshold helpers. No dependencies.
package rclas_pkg;

    // Receiver channel width and link recovery depth
    localparam int CHANNEL_BITS    = 11;
    localparam int STREAK_BITS     = 4;
    localparam int COUNT_BITS      = 8;
    localparam int HYST_BITS       = 9;
    localparam logic [STREAK_BITS-1:0] RECOVER_WINDOWS = STREAK_BITS'(1);
    localparam logic [STREAK_BITS-1:0] STREAK_MAX      = '1;

    typedef logic [CHANNEL_BITS-1:0] ch_t;
    typedef logic [COUNT_BITS-1:0]   cnt_t;
    typedef logic [HYST_BITS-1:0]    hyst_t;
    typedef logic [STREAK_BITS-1:0]  streak_t;

    // Stream widths: tdata is padded to whole bytes
    localparam int IN_BITS       = 3 + 6 * CHANNEL_BITS;
    localparam int IN_DATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = 11;
    localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // Input tdata field offsets, lowest first
    localparam int OFS_FAILSAFE = 0;
    localparam int OFS_LOST     = 1;
    localparam int OFS_ROLL     = 2;
    localparam int OFS_PITCH    = OFS_ROLL + CHANNEL_BITS;
    localparam int OFS_YAW      = OFS_PITCH + CHANNEL_BITS;
    localparam int OFS_THROTTLE = OFS_YAW + CHANNEL_BITS;
    localparam int OFS_ARM      = OFS_THROTTLE + CHANNEL_BITS;
    localparam int OFS_MODE_CH  = OFS_ARM + CHANNEL_BITS;
    localparam int OFS_PERMIT   = OFS_MODE_CH + CHANNEL_BITS;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_STICK_MIN       = 3'd0,
        REG_STICK_MAX       = 3'd1,
        REG_WINDOW_FRAMES   = 3'd2,
        REG_LOST_LIMIT      = 3'd3,
        REG_ARM_LEVEL       = 3'd4,
        REG_MODE_LOW_LEVEL  = 3'd5,
        REG_MODE_HIGH_LEVEL = 3'd6,
        REG_MODE_HYSTERESIS = 3'd7
    } cfg_reg_e;

    // Flight mode codes
    typedef enum logic [1:0] {
        FM_STABILIZE = 2'd0,
        FM_ALT_HOLD  = 2'd1,
        FM_POS_HOLD  = 2'd2,
        FM_UNUSED    = 2'd3
    } flight_mode_e;

    // Event kind carried on s_tuser
    localparam logic EV_FRAME       = 1'b0;
    localparam logic EV_RX_MISSING  = 1'b1;

    typedef struct packed {
        ch_t   stick_min;
        ch_t   stick_max;
        cnt_t  window_frames;
        cnt_t  lost_limit;
        ch_t   arm_level;
        ch_t   mode_low_level;
        ch_t   mode_high_level;
        hyst_t mode_hysteresis;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        stick_min:       ch_t'(180),
        stick_max:       ch_t'(1850),
        window_frames:   cnt_t'(25),
        lost_limit:      cnt_t'(20),
        arm_level:       ch_t'(1500),
        mode_low_level:  ch_t'(600),
        mode_high_level: ch_t'(1400),
        mode_hysteresis: hyst_t'(100)
    };

    typedef struct packed {
        logic rx_missing;
        logic failsafe_flag;
        logic lost_flag;
        ch_t  roll_channel;
        ch_t  pitch_channel;
        ch_t  yaw_channel;
        ch_t  throttle_channel;
        ch_t  arm_channel;
        ch_t  mode_channel;
        logic arm_permitted;
    } item_t;

    typedef struct packed {
        logic         frame_valid;
        logic         link_lost;
        logic         armed;
        logic         arm_refused;
        logic         forced_disarm;
        logic         rc_connected;
        flight_mode_e flight_mode;
        logic         mode_changed;
        logic         setpoint_sent;
        logic         window_closed;
    } result_t;

    // Unpack one input transfer
    function automatic item_t unpack_item(logic [IN_DATA_BITS-1:0] d, logic kind);
        item_t it;
        it.rx_missing       = (kind == EV_RX_MISSING);
        it.failsafe_flag    = d[OFS_FAILSAFE];
        it.lost_flag        = d[OFS_LOST];
        it.roll_channel     = d[OFS_ROLL +: CHANNEL_BITS];
        it.pitch_channel    = d[OFS_PITCH +: CHANNEL_BITS];
        it.yaw_channel      = d[OFS_YAW +: CHANNEL_BITS];
        it.throttle_channel = d[OFS_THROTTLE +: CHANNEL_BITS];
        it.arm_channel      = d[OFS_ARM +: CHANNEL_BITS];
        it.mode_channel     = d[OFS_MODE_CH +: CHANNEL_BITS];
        it.arm_permitted    = d[OFS_PERMIT];
        return it;
    endfunction

    // Pack one result, frame_valid in bit 0
    function automatic logic [OUT_DATA_BITS-1:0] pack_result(result_t r);
        logic [OUT_DATA_BITS-1:0] d;
        d = '0;
        d[0]   = r.frame_valid;
        d[1]   = r.link_lost;
        d[2]   = r.armed;
        d[3]   = r.arm_refused;
        d[4]   = r.forced_disarm;
        d[5]   = r.rc_connected;
        d[7:6] = r.flight_mode;
        d[8]   = r.mode_changed;
        d[9]   = r.setpoint_sent;
        d[10]  = r.window_closed;
        return d;
    endfunction

    // level + margin, saturating at the channel full scale
    function automatic ch_t clamp_up(ch_t lvl, hyst_t h);
        logic [CHANNEL_BITS:0] s;
        s = {1'b0, lvl} + (CHANNEL_BITS+1)'(h);
        return s[CHANNEL_BITS] ? '1 : s[CHANNEL_BITS-1:0];
    endfunction

    // level - margin, saturating at zero
    function automatic ch_t clamp_dn(ch_t lvl, hyst_t h);
        logic [CHANNEL_BITS:0] s;
        s = {1'b0, lvl} - (CHANNEL_BITS+1)'(h);
        return s[CHANNEL_BITS] ? '0 : s[CHANNEL_BITS-1:0];
    endfunction

endpackage

// ===== sv/rclas_cfg_regs.sv =====
// Configuration register file of the RC link supervisor.
// Depends on rclas_pkg for the register codes and reset values.
module rclas_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rclas_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [rclas_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output rclas_pkg::cfg_t                     cfg
);

    rclas_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode one write transfer into the addressed field
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (rclas_pkg::cfg_reg_e'(cfg_addr))
                rclas_pkg::REG_STICK_MIN:
                    cfg_next.stick_min = cfg_data[rclas_pkg::CHANNEL_BITS-1:0];
                rclas_pkg::REG_STICK_MAX:
                    cfg_next.stick_max = cfg_data[rclas_pkg::CHANNEL_BITS-1:0];
                rclas_pkg::REG_WINDOW_FRAMES:
                    cfg_next.window_frames = cfg_data[rclas_pkg::COUNT_BITS-1:0];
                rclas_pkg::REG_LOST_LIMIT:
                    cfg_next.lost_limit = cfg_data[rclas_pkg::COUNT_BITS-1:0];
                rclas_pkg::REG_ARM_LEVEL:
                    cfg_next.arm_level = cfg_data[rclas_pkg::CHANNEL_BITS-1:0];
                rclas_pkg::REG_MODE_LOW_LEVEL:
                    cfg_next.mode_low_level = cfg_data[rclas_pkg::CHANNEL_BITS-1:0];
                rclas_pkg::REG_MODE_HIGH_LEVEL:
                    cfg_next.mode_high_level = cfg_data[rclas_pkg::CHANNEL_BITS-1:0];
                rclas_pkg::REG_MODE_HYSTERESIS:
                    cfg_next.mode_hysteresis = cfg_data[rclas_pkg::HYST_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= rclas_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/rclas_supervisor.sv =====
// Link quality, arm and flight mode state of the RC link supervisor.
// Computes one result from the registered item and updates state on step.
// Depends on rclas_pkg.
module rclas_supervisor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  rclas_pkg::cfg_t     cfg,
    input  rclas_pkg::item_t    item,
    output rclas_pkg::result_t  result
);

    rclas_pkg::cnt_t         good_reg, good_next;
    rclas_pkg::cnt_t         bad_reg, bad_next;
    logic                    lost_reg, lost_next;
    rclas_pkg::streak_t      streak_reg, streak_next;
    logic                    armed_reg, armed_next;
    logic                    conn_reg, conn_next;
    rclas_pkg::flight_mode_e fmode_reg, fmode_next;

    logic                    sticks_ok;
    logic                    valid;
    logic                    sw_on;
    logic [rclas_pkg::COUNT_BITS:0] total;
    rclas_pkg::ch_t          low_thr, high_thr;
    rclas_pkg::flight_mode_e mode_sel;

    // Stick range check
    always_comb begin
        sticks_ok = (item.roll_channel >= cfg.stick_min)
                 && (item.roll_channel <= cfg.stick_max)
                 && (item.pitch_channel >= cfg.stick_min)
                 && (item.pitch_channel <= cfg.stick_max)
                 && (item.yaw_channel >= cfg.stick_min)
                 && (item.yaw_channel <= cfg.stick_max)
                 && (item.throttle_channel >= cfg.stick_min)
                 && (item.throttle_channel <= cfg.stick_max);
        valid = !item.rx_missing && !item.failsafe_flag && !item.lost_flag && sticks_ok;
        sw_on = item.arm_channel > cfg.arm_level;
    end

    // Mode thresholds with hysteresis around the current position
    always_comb begin
        case (fmode_reg)
            rclas_pkg::FM_STABILIZE: begin
                low_thr  = rclas_pkg::clamp_up(cfg.mode_low_level, cfg.mode_hysteresis);
                high_thr = cfg.mode_high_level;
            end
            rclas_pkg::FM_ALT_HOLD: begin
                low_thr  = rclas_pkg::clamp_dn(cfg.mode_low_level, cfg.mode_hysteresis);
                high_thr = rclas_pkg::clamp_up(cfg.mode_high_level, cfg.mode_hysteresis);
            end
            default: begin
                low_thr  = cfg.mode_low_level;
                high_thr = rclas_pkg::clamp_dn(cfg.mode_high_level, cfg.mode_hysteresis);
            end
        endcase
        if (item.mode_channel < low_thr) begin
            mode_sel = rclas_pkg::FM_STABILIZE;
        end else if (item.mode_channel >= high_thr) begin
            mode_sel = rclas_pkg::FM_POS_HOLD;
        end else begin
            mode_sel = rclas_pkg::FM_ALT_HOLD;
        end
    end

    // Next state and result for the item
    always_comb begin
        good_next   = good_reg;
        bad_next    = bad_reg;
        lost_next   = lost_reg;
        streak_next = streak_reg;
        armed_next  = armed_reg;
        conn_next   = conn_reg;
        fmode_next  = fmode_reg;
        total       = '0;
        result      = '0;

        if (item.rx_missing) begin
            // Receiver gone: drop connection, force disarm
            result.forced_disarm = armed_reg;
            armed_next           = 1'b0;
            conn_next            = 1'b0;
        end else begin
            if (valid) begin
                good_next = good_reg + rclas_pkg::cnt_t'(1);
            end else begin
                bad_next = bad_reg + rclas_pkg::cnt_t'(1);
            end
            total = {1'b0, good_next} + {1'b0, bad_next};

            // Window close decision
            if (total >= {1'b0, cfg.window_frames}) begin
                result.window_closed = 1'b1;
                if (bad_next >= cfg.lost_limit) begin
                    streak_next = '0;
                    if (!lost_reg) begin
                        lost_next            = 1'b1;
                        result.forced_disarm = armed_reg;
                        armed_next           = 1'b0;
                        conn_next            = 1'b0;
                    end
                end else if (lost_reg) begin
                    if (streak_reg != rclas_pkg::STREAK_MAX) begin
                        streak_next = streak_reg + rclas_pkg::streak_t'(1);
                    end
                    if (streak_next >= rclas_pkg::RECOVER_WINDOWS) begin
                        lost_next = 1'b0;
                        conn_next = 1'b1;
                    end
                end else begin
                    streak_next = rclas_pkg::RECOVER_WINDOWS;
                end
                good_next = '0;
                bad_next  = '0;
            end

            // Valid frame on a live link: arm switch and mode switch
            if (!lost_next && valid) begin
                if (sw_on && !armed_next) begin
                    if (item.arm_permitted) begin
                        armed_next = 1'b1;
                    end else begin
                        result.arm_refused = 1'b1;
                    end
                end else if (!sw_on && armed_next) begin
                    armed_next = 1'b0;
                end
                conn_next            = 1'b1;
                result.mode_changed  = (mode_sel != fmode_reg);
                fmode_next           = mode_sel;
                result.setpoint_sent = 1'b1;
            end
        end

        result.frame_valid  = valid;
        result.link_lost    = lost_next;
        result.armed        = armed_next;
        result.rc_connected = conn_next;
        result.flight_mode  = fmode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_reg   <= '0;
            bad_reg    <= '0;
            lost_reg   <= 1'b1;
            streak_reg <= '0;
            armed_reg  <= 1'b0;
            conn_reg   <= 1'b0;
            fmode_reg  <= rclas_pkg::FM_STABILIZE;
        end else if (step) begin
            good_reg   <= good_next;
            bad_reg    <= bad_next;
            lost_reg   <= lost_next;
            streak_reg <= streak_next;
            armed_reg  <= armed_next;
            conn_reg   <= conn_next;
            fmode_reg  <= fmode_next;
        end
    end

endmodule

// ===== sv/rc_link_arm_mode_supervisor.sv =====
// Top level of the RC link and arm/mode supervisor: input register, result
// register and stream handshakes. Uses rclas_pkg, rclas_cfg_regs, rclas_supervisor.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata (frame fields), s_tuser (event kind)
//  m_        out  m_tvalid / m_tready    m_tdata (result fields)
//  cfg_      in   cfg_valid / cfg_ready  cfg_addr, cfg_data
//
// An input transfer loads the input register; when the result register is empty
// or its result is being taken, the item steps into it and m_tvalid rises. One
// item per cycle is sustained while m_tready is high, set by the single input
// register feeding the result register through the state update logic.
// Reset (aresetn low, synchronous) empties both registers and restores
// register defaults; the link starts lost. cfg_ready is always high.
// A stalled m_ side holds the result and the item behind it; s_tready drops
// only when both are full.
module rc_link_arm_mode_supervisor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // failsafe_flag, lost_flag, roll_channel, pitch_channel, yaw_channel,
    // throttle_channel, arm_channel, mode_channel, arm_permitted, zero pad
    input  logic [rclas_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // event kind: frame or receiver missing
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // frame_valid, link_lost, armed, arm_refused, forced_disarm, rc_connected,
    // flight_mode[1:0], mode_changed, setpoint_sent, window_closed, zero pad
    output logic [rclas_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rclas_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [rclas_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    rclas_pkg::cfg_t    cfg;
    rclas_pkg::item_t   item_reg;
    rclas_pkg::result_t result;
    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [rclas_pkg::OUT_DATA_BITS-1:0] out_data_reg;
    logic               advance;
    logic               step;
    logic               s_xfer;

    rclas_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rclas_supervisor u_sup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (result)
    );

    // Pipeline flow control
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg <= rclas_pkg::unpack_item(s_tdata, s_tuser);
        end
        if (step) begin
            out_data_reg <= rclas_pkg::pack_result(result);
        end
    end

endmodule

// ===== sv/rclas_checker.sv =====
// Port-level checks for the RC link supervisor, bound to the top level.
// Depends on rclas_pkg for stream widths.
module rclas_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rclas_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Flight mode code three never appears
    a_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:6] != 2'd3)
        else $error("unused flight mode code");

    // A lost link is never armed
    a_lost_disarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tdata[2])
        else $error("armed while link lost");

    // Forced disarm leaves the vehicle disarmed and disconnected
    a_forced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tdata[2] && !m_tdata[5])
        else $error("forced disarm inconsistent");

    // A setpoint only comes from a valid frame on a live, connected link
    a_setpoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[0] && !m_tdata[1] && m_tdata[5])
        else $error("setpoint without live valid frame");

endmodule

bind rc_link_arm_mode_supervisor rclas_checker u_rclas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
